@@ design/de9im_pkg.sv @@
// de9im_pkg: relation and box case codes, standard mask constants and stage payload types
// shared by every stage of the de9im classifier; depends on nothing

package de9im_pkg;

    // relation codes
    localparam logic [2:0] REL_DISJOINT   = 3'd0;
    localparam logic [2:0] REL_INSIDE     = 3'd1;
    localparam logic [2:0] REL_COVERED_BY = 3'd2;
    localparam logic [2:0] REL_MEET       = 3'd3;
    localparam logic [2:0] REL_INTERSECT  = 3'd4;
    localparam logic [2:0] REL_CONTAINS   = 3'd5;
    localparam logic [2:0] REL_COVERS     = 3'd6;
    localparam logic [2:0] REL_EQUAL      = 3'd7;

    // status codes
    localparam logic STATUS_OK          = 1'b0;
    localparam logic STATUS_INVALID_BOX = 1'b1;

    // bounding-box relation cases
    localparam logic [2:0] BOX_R_IN_S    = 3'd0;
    localparam logic [2:0] BOX_S_IN_R    = 3'd1;
    localparam logic [2:0] BOX_EQUAL     = 3'd2;
    localparam logic [2:0] BOX_INTERSECT = 3'd3;

    localparam int NUM_CELLS = 9;

    // a mask is a care vector and a value vector; bit i is matrix cell i in row-major order
    typedef struct packed {
        logic [NUM_CELLS-1:0] care;
        logic [NUM_CELLS-1:0] value;
    } mask_t;

    localparam mask_t MASK_DISJOINT = '{care: 9'h01B, value: 9'h000}; // FF*FF****
    localparam mask_t MASK_INSIDE   = '{care: 9'h025, value: 9'h001}; // T*F**F***
    localparam mask_t MASK_COVBY_B  = '{care: 9'h026, value: 9'h002}; // *TF**F***
    localparam mask_t MASK_COVBY_C  = '{care: 9'h02C, value: 9'h008}; // **FT*F***
    localparam mask_t MASK_COVBY_D  = '{care: 9'h034, value: 9'h010}; // **F*TF***
    localparam mask_t MASK_CONTAINS = '{care: 9'h0C1, value: 9'h001}; // T*****FF*
    localparam mask_t MASK_COVERS_B = '{care: 9'h0C2, value: 9'h002}; // *T****FF*
    localparam mask_t MASK_COVERS_C = '{care: 9'h0C8, value: 9'h008}; // ***T**FF*
    localparam mask_t MASK_COVERS_D = '{care: 9'h0D0, value: 9'h010}; // ****T*FF*
    localparam mask_t MASK_MEET_A   = '{care: 9'h003, value: 9'h002}; // FT*******
    localparam mask_t MASK_MEET_B   = '{care: 9'h009, value: 9'h008}; // F**T*****
    localparam mask_t MASK_MEET_C   = '{care: 9'h011, value: 9'h010}; // F***T****
    localparam mask_t MASK_EQUAL    = '{care: 9'h0E5, value: 9'h001}; // T*F**FFF*

    // first stage payload: emptiness of each cell plus the box case
    typedef struct packed {
        logic [NUM_CELLS-1:0] nonempty;
        logic [2:0]           box_case;
    } cell_item_t;

    // second stage payload: which mask groups matched
    typedef struct packed {
        logic       disjoint;
        logic       inside_fit;
        logic       covby_any;
        logic       contains;
        logic       covers_any;
        logic       meet_any;
        logic       equal;
        logic [2:0] box_case;
    } hit_item_t;

    function automatic logic mask_hit(input logic [NUM_CELLS-1:0] nonempty, input mask_t m);
        mask_hit = ((nonempty ^ m.value) & m.care) == '0;
    endfunction

endpackage

@@ design/de9im_if.sv @@
// de9im_if: valid/ready channel interfaces for matrix transactions and relation transactions
// depends on nothing

interface de9im_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cell_ii;
    logic [1:0] cell_ib;
    logic [1:0] cell_ie;
    logic [1:0] cell_bi;
    logic [1:0] cell_bb;
    logic [1:0] cell_be;
    logic [1:0] cell_ei;
    logic [1:0] cell_eb;
    logic [1:0] cell_ee;
    logic [2:0] box_case;

    modport source (
        output valid, cell_ii, cell_ib, cell_ie, cell_bi, cell_bb, cell_be,
               cell_ei, cell_eb, cell_ee, box_case,
        input  ready
    );
    modport sink (
        input  valid, cell_ii, cell_ib, cell_ie, cell_bi, cell_bb, cell_be,
               cell_ei, cell_eb, cell_ee, box_case,
        output ready
    );
endinterface

interface de9im_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] relation;
    logic       status;

    modport source (output valid, relation, status, input ready);
    modport sink (input valid, relation, status, output ready);
endinterface

@@ design/de9im_decode.sv @@
// de9im_decode: first pipeline stage, reduces each matrix cell to an empty/non-empty flag
// depends on de9im_pkg and de9im_in_if

module de9im_decode
    import de9im_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    de9im_in_if.sink       pair,
    output logic           out_valid,
    input  logic           out_ready,
    output cell_item_t     out_item
);

    logic       valid_reg;
    logic       valid_next;
    cell_item_t item_reg;
    cell_item_t item_next;
    logic       take;

    assign pair.ready = !valid_reg || out_ready;
    assign take       = pair.valid && pair.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (pair.ready)
        begin
            valid_next = pair.valid;
        end
        item_next.nonempty = {
            pair.cell_ee != 2'd0, pair.cell_eb != 2'd0, pair.cell_ei != 2'd0,
            pair.cell_be != 2'd0, pair.cell_bb != 2'd0, pair.cell_bi != 2'd0,
            pair.cell_ie != 2'd0, pair.cell_ib != 2'd0, pair.cell_ii != 2'd0
        };
        item_next.box_case = pair.box_case;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

@@ design/de9im_match.sv @@
// de9im_match: second pipeline stage, tests the non-empty pattern against every standard mask
// depends on de9im_pkg

module de9im_match
    import de9im_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  cell_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output hit_item_t  out_item
);

    logic       valid_reg;
    logic       valid_next;
    hit_item_t  item_reg;
    hit_item_t  item_next;
    logic       take;
    logic       inside_hit;
    logic       contains_hit;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
        inside_hit   = mask_hit(in_item.nonempty, MASK_INSIDE);
        contains_hit = mask_hit(in_item.nonempty, MASK_CONTAINS);

        item_next.disjoint   = mask_hit(in_item.nonempty, MASK_DISJOINT);
        item_next.inside_fit = inside_hit;
        item_next.covby_any  = inside_hit
                             || mask_hit(in_item.nonempty, MASK_COVBY_B)
                             || mask_hit(in_item.nonempty, MASK_COVBY_C)
                             || mask_hit(in_item.nonempty, MASK_COVBY_D);
        item_next.contains   = contains_hit;
        item_next.covers_any = contains_hit
                             || mask_hit(in_item.nonempty, MASK_COVERS_B)
                             || mask_hit(in_item.nonempty, MASK_COVERS_C)
                             || mask_hit(in_item.nonempty, MASK_COVERS_D);
        item_next.meet_any   = mask_hit(in_item.nonempty, MASK_MEET_A)
                             || mask_hit(in_item.nonempty, MASK_MEET_B)
                             || mask_hit(in_item.nonempty, MASK_MEET_C);
        item_next.equal      = mask_hit(in_item.nonempty, MASK_EQUAL);
        item_next.box_case   = in_item.box_case;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

@@ design/de9im_resolve.sv @@
// de9im_resolve: last pipeline stage, walks the priority chain chosen by the box case
// depends on de9im_pkg and de9im_out_if

module de9im_resolve
    import de9im_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  hit_item_t  in_item,
    de9im_out_if.source result
);

    logic       valid_reg;
    logic       valid_next;
    logic [2:0] relation_reg;
    logic [2:0] relation_next;
    logic       status_reg;
    logic       status_next;
    logic       take;

    assign in_ready = !valid_reg || result.ready;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
        status_next   = STATUS_OK;
        relation_next = REL_INTERSECT;
        case (in_item.box_case)
            BOX_R_IN_S:
            begin
                if (in_item.disjoint)
                    relation_next = REL_DISJOINT;
                else if (in_item.covby_any)
                    relation_next = in_item.inside_fit ? REL_INSIDE : REL_COVERED_BY;
                else if (in_item.meet_any)
                    relation_next = REL_MEET;
            end
            BOX_S_IN_R:
            begin
                if (in_item.disjoint)
                    relation_next = REL_DISJOINT;
                else if (in_item.covers_any)
                    relation_next = in_item.contains ? REL_CONTAINS : REL_COVERS;
                else if (in_item.meet_any)
                    relation_next = REL_MEET;
            end
            BOX_EQUAL:
            begin
                if (in_item.equal)
                    relation_next = REL_EQUAL;
                else if (in_item.covers_any)
                    relation_next = REL_CONTAINS;
                else if (in_item.covby_any)
                    relation_next = REL_INSIDE;
            end
            BOX_INTERSECT:
            begin
                if (in_item.disjoint)
                    relation_next = REL_DISJOINT;
                else if (in_item.meet_any)
                    relation_next = REL_MEET;
            end
            default:
            begin
                relation_next = REL_DISJOINT;
                status_next   = STATUS_INVALID_BOX;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            relation_reg <= relation_next;
            status_reg   <= status_next;
        end
    end

    assign result.valid    = valid_reg;
    assign result.relation = relation_reg;
    assign result.status   = status_reg;

endmodule

@@ design/de9im_topology_classifier.sv @@
// de9im_topology_classifier: top level of the de9im relation classifier
// depends on de9im_pkg, de9im_if, de9im_decode, de9im_match and de9im_resolve

// Classifies one precomputed DE-9IM matrix per transaction on the pair channel and returns
// one relation code with a status on the result channel. The block is a three-stage
// pipeline (cell decode, mask matching, priority resolution), each stage a register with
// its own valid bit, so a new transaction is taken in every cycle while the result channel
// is not stalled, and each result passes the decode, match and resolve registers in order.
// Back-pressure travels stage by stage: a stage takes a transaction whenever it is empty
// or its content moves on in the same cycle, so a full pipeline holds three transactions
// and keeps taking one per cycle while results are consumed. Only emptiness of a cell
// matters; dimensions 0, 1 and 2 are treated alike. A box case outside 0..3 returns
// status 1 with relation 0. There is no configuration and no state beyond the pipeline.

module de9im_topology_classifier
    import de9im_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    de9im_in_if.sink     pair,
    de9im_out_if.source  result
);

    // stage one to stage two
    logic       decode_valid;
    logic       match_ready;
    cell_item_t decode_item;

    // stage two to stage three
    logic       match_valid;
    logic       resolve_ready;
    hit_item_t  match_item;

    // cell emptiness flags
    de9im_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .pair      (pair),
        .out_valid (decode_valid),
        .out_ready (match_ready),
        .out_item  (decode_item)
    );

    // standard mask hits
    de9im_match u_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (decode_valid),
        .in_ready  (match_ready),
        .in_item   (decode_item),
        .out_valid (match_valid),
        .out_ready (resolve_ready),
        .out_item  (match_item)
    );

    // priority chain per box case, registered result
    de9im_resolve u_resolve (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (match_valid),
        .in_ready (resolve_ready),
        .in_item  (match_item),
        .result   (result)
    );

endmodule

@@ test/tb_de9im_topology_classifier.sv @@
`timescale 1ns / 100ps
// tb_de9im_topology_classifier: self-checking bench for the de9im relation classifier
// depends on de9im_pkg, de9im_if and the de9im_topology_classifier top level

module tb_de9im_topology_classifier;
    import de9im_pkg::*;

    // box case codes outside the defined four, all of which must flag an invalid status
    localparam logic [2:0] BOX_UNUSED_4 = 3'd4;
    localparam logic [2:0] BOX_UNUSED_5 = 3'd5;
    localparam logic [2:0] BOX_UNUSED_6 = 3'd6;
    localparam logic [2:0] BOX_UNUSED_7 = 3'd7;

    localparam int LIMIT_CYCLES   = 200000;
    localparam int RANDOM_PER_RUN = 330;
    localparam int DRAIN_CYCLES   = 8;
    localparam int NUM_ROWS       = 25;
    localparam int NUM_SHAPES     = 13;

    // one matrix transaction; cells[0] is interior-interior, cells[8] exterior-exterior
    typedef struct packed {
        logic [8:0][1:0] cells;
        logic [2:0]      box_case;
    } matrix_txn_t;

    typedef struct packed {
        logic [2:0] relation;
        logic       status;
    } verdict_t;

    // directed row: nine cell digits written ii..ee left to right, box case, and an
    // optional hand-typed answer
    typedef struct packed {
        logic [35:0] digits;
        logic [2:0]  box_case;
        logic        typed;
        logic [2:0]  relation;
        logic        status;
    } script_row_t;

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   mismatch_count;
    int   send_gap_pct;
    int   take_gap_pct;

    verdict_t pending_verdicts[$];
    verdict_t typed_verdicts[$];
    bit       typed_flags[$];

    de9im_in_if  pair_if ();
    de9im_out_if result_if ();

    de9im_topology_classifier dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pair   (pair_if.sink),
        .result (result_if.source)
    );

    // directed script: reset-like all-empty matrices, all-full matrices, every invalid
    // box case, then rows for every relation reachable in each chain but S-in-R meet
    script_row_t script [NUM_ROWS] = '{
        '{36'h000000000, BOX_R_IN_S,    1'b1, REL_DISJOINT,  STATUS_OK},
        '{36'h000000000, BOX_S_IN_R,    1'b1, REL_DISJOINT,  STATUS_OK},
        '{36'h000000000, BOX_INTERSECT, 1'b1, REL_DISJOINT,  STATUS_OK},
        '{36'h000000000, BOX_EQUAL,     1'b0, REL_DISJOINT,  STATUS_OK},
        '{36'h333333333, BOX_R_IN_S,    1'b1, REL_INTERSECT, STATUS_OK},
        '{36'h333333333, BOX_S_IN_R,    1'b1, REL_INTERSECT, STATUS_OK},
        '{36'h333333333, BOX_EQUAL,     1'b1, REL_INTERSECT, STATUS_OK},
        '{36'h333333333, BOX_INTERSECT, 1'b1, REL_INTERSECT, STATUS_OK},
        '{36'h333333333, BOX_UNUSED_4,  1'b1, REL_DISJOINT,  STATUS_INVALID_BOX},
        '{36'h333333333, BOX_UNUSED_5,  1'b1, REL_DISJOINT,  STATUS_INVALID_BOX},
        '{36'h000000000, BOX_UNUSED_6,  1'b1, REL_DISJOINT,  STATUS_INVALID_BOX},
        '{36'h123123123, BOX_UNUSED_7,  1'b1, REL_DISJOINT,  STATUS_INVALID_BOX},
        '{36'h100000000, BOX_R_IN_S,    1'b0, REL_DISJOINT,  STATUS_OK},
        '{36'h020000000, BOX_R_IN_S,    1'b0, REL_DISJOINT,  STATUS_OK},
        '{36'h000200000, BOX_R_IN_S,    1'b0, REL_DISJOINT,  STATUS_OK},
        '{36'h000030000, BOX_R_IN_S,    1'b0, REL_DISJOINT,  STATUS_OK},
        '{36'h010000000, BOX_INTERSECT, 1'b0, REL_DISJOINT,  STATUS_OK},
        '{36'h100000000, BOX_S_IN_R,    1'b0, REL_DISJOINT,  STATUS_OK},
        '{36'h000010000, BOX_S_IN_R,    1'b0, REL_DISJOINT,  STATUS_OK},
        '{36'h200000000, BOX_EQUAL,     1'b0, REL_DISJOINT,  STATUS_OK},
        '{36'h032000000, BOX_EQUAL,     1'b0, REL_DISJOINT,  STATUS_OK},
        '{36'h010000230, BOX_EQUAL,     1'b0, REL_DISJOINT,  STATUS_OK},
        '{36'h012000000, BOX_R_IN_S,    1'b0, REL_DISJOINT,  STATUS_OK},
        '{36'h300000003, BOX_S_IN_R,    1'b0, REL_DISJOINT,  STATUS_OK},
        '{36'h000101000, BOX_R_IN_S,    1'b0, REL_DISJOINT,  STATUS_OK}
    };

    // every standard pattern; random matrices are often grown from one of these so that
    // the deeper branches of each chain are reached
    string shapes [NUM_SHAPES] = '{
        "FF*FF****", "T*F**F***", "*TF**F***", "**FT*F***", "**F*TF***",
        "T*****FF*", "*T****FF*", "***T**FF*", "****T*FF*",
        "FT*******", "F**T*****", "F***T****", "T*F**FFF*"
    };

    // clock, 4 ns period
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // pattern letters: T needs a non-empty cell, F an empty one, * takes either
    function automatic bit fits(input logic [8:0] filled, input string pattern);
        for (int i = 0; i < 9; i++)
        begin
            if (pattern[i] == "T" && !filled[i])
                return 1'b0;
            if (pattern[i] == "F" && filled[i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // expected relation and status for one matrix transaction
    function automatic verdict_t classify_matrix(input matrix_txn_t txn);
        logic [8:0] filled;
        bit         apart;
        bit         touch;
        bit         covered;
        bit         covering;
        verdict_t   v;
        for (int i = 0; i < 9; i++)
            filled[i] = (txn.cells[i] != 2'd0);
        apart    = fits(filled, "FF*FF****");
        touch    = fits(filled, "FT*******") || fits(filled, "F**T*****")
                   || fits(filled, "F***T****");
        covered  = fits(filled, "T*F**F***") || fits(filled, "*TF**F***")
                   || fits(filled, "**FT*F***") || fits(filled, "**F*TF***");
        covering = fits(filled, "T*****FF*") || fits(filled, "*T****FF*")
                   || fits(filled, "***T**FF*") || fits(filled, "****T*FF*");
        v.status = STATUS_OK;
        case (txn.box_case)
            BOX_R_IN_S:
            begin
                if (apart)
                    v.relation = REL_DISJOINT;
                else if (covered)
                    v.relation = fits(filled, "T*F**F***") ? REL_INSIDE : REL_COVERED_BY;
                else if (touch)
                    v.relation = REL_MEET;
                else
                    v.relation = REL_INTERSECT;
            end
            BOX_S_IN_R:
            begin
                if (apart)
                    v.relation = REL_DISJOINT;
                else if (covering)
                    v.relation = fits(filled, "T*****FF*") ? REL_CONTAINS : REL_COVERS;
                else if (touch)
                    v.relation = REL_MEET;
                else
                    v.relation = REL_INTERSECT;
            end
            BOX_EQUAL:
            begin
                if (fits(filled, "T*F**FFF*"))
                    v.relation = REL_EQUAL;
                else if (covering)
                    v.relation = REL_CONTAINS;
                else if (covered)
                    v.relation = REL_INSIDE;
                else
                    v.relation = REL_INTERSECT;
            end
            BOX_INTERSECT:
            begin
                if (apart)
                    v.relation = REL_DISJOINT;
                else if (touch)
                    v.relation = REL_MEET;
                else
                    v.relation = REL_INTERSECT;
            end
            default:
            begin
                v.relation = REL_DISJOINT;
                v.status   = STATUS_INVALID_BOX;
            end
        endcase
        return v;
    endfunction

    // three in four matrices follow a standard pattern with random don't-care cells,
    // the rest are raw noise; about one in eight carries an invalid box case
    function automatic matrix_txn_t make_random_matrix();
        matrix_txn_t txn;
        logic [8:0]  filled;
        string       pattern;
        filled = 9'($urandom());
        if ($urandom_range(3) != 0)
        begin
            pattern = shapes[$urandom_range(NUM_SHAPES - 1)];
            for (int i = 0; i < 9; i++)
            begin
                if (pattern[i] == "T")
                    filled[i] = 1'b1;
                else if (pattern[i] == "F")
                    filled[i] = 1'b0;
            end
        end
        for (int i = 0; i < 9; i++)
            txn.cells[i] = filled[i] ? 2'($urandom_range(3, 1)) : 2'd0;
        if ($urandom_range(7) == 0)
            txn.box_case = 3'($urandom_range(7, 4));
        else
            txn.box_case = 3'($urandom_range(3));
        return txn;
    endfunction

    // present one transaction from a falling edge and hold it until it is taken;
    // returns at the falling edge after acceptance
    task automatic send_matrix(input matrix_txn_t txn, input bit typed, input verdict_t answer);
        while ($urandom_range(99) < send_gap_pct)
        begin
            pair_if.valid <= 1'b0;
            @(negedge clk);
        end
        pair_if.cell_ii  <= txn.cells[0];
        pair_if.cell_ib  <= txn.cells[1];
        pair_if.cell_ie  <= txn.cells[2];
        pair_if.cell_bi  <= txn.cells[3];
        pair_if.cell_bb  <= txn.cells[4];
        pair_if.cell_be  <= txn.cells[5];
        pair_if.cell_ei  <= txn.cells[6];
        pair_if.cell_eb  <= txn.cells[7];
        pair_if.cell_ee  <= txn.cells[8];
        pair_if.box_case <= txn.box_case;
        pair_if.valid    <= 1'b1;
        typed_flags.push_back(typed);
        typed_verdicts.push_back(answer);
        do
            @(posedge clk);
        while (!pair_if.ready);
        @(negedge clk);
    endtask

    // hold the sender back until every outstanding result has come out
    task automatic wait_for_results();
        pair_if.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // receiver stalls at random, re-decided every falling edge
    always @(negedge clk)
        result_if.ready <= ($urandom_range(99) >= take_gap_pct);

    // predictor and checker share one sampling point; accepted matrices are queued
    // before results are compared so ordering never depends on event order
    always @(posedge clk)
    begin
        matrix_txn_t txn;
        verdict_t    want;
        bit          typed;
        verdict_t    answer;
        cycle_count++;
        if (rst_n && pair_if.valid && pair_if.ready)
        begin
            txn.cells[0] = pair_if.cell_ii;
            txn.cells[1] = pair_if.cell_ib;
            txn.cells[2] = pair_if.cell_ie;
            txn.cells[3] = pair_if.cell_bi;
            txn.cells[4] = pair_if.cell_bb;
            txn.cells[5] = pair_if.cell_be;
            txn.cells[6] = pair_if.cell_ei;
            txn.cells[7] = pair_if.cell_eb;
            txn.cells[8] = pair_if.cell_ee;
            txn.box_case = pair_if.box_case;
            typed  = typed_flags.pop_front();
            answer = typed_verdicts.pop_front();
            // a hand-typed answer from the script takes precedence over the predictor
            pending_verdicts.push_back(typed ? answer : classify_matrix(txn));
        end
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result with nothing outstanding, got relation %0d status %0d",
                         $time, result_if.relation, result_if.status);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (result_if.relation !== want.relation)
                begin
                    mismatch_count++;
                    $display("%0t: relation expected %0d, got %0d",
                             $time, want.relation, result_if.relation);
                end
                if (result_if.status !== want.status)
                begin
                    mismatch_count++;
                    $display("%0t: status expected %0d, got %0d",
                             $time, want.status, result_if.status);
                end
            end
        end
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("de9im_topology_classifier: mismatch");
            $finish;
        end
    end

    initial
    begin
        matrix_txn_t txn;
        verdict_t    answer;
        cycle_count      = 0;
        mismatch_count   = 0;
        send_gap_pct     = 13;
        take_gap_pct     = 56;
        rst_n            = 1'b0;
        pair_if.valid    = 1'b0;
        pair_if.cell_ii  = 2'd0;
        pair_if.cell_ib  = 2'd0;
        pair_if.cell_ie  = 2'd0;
        pair_if.cell_bi  = 2'd0;
        pair_if.cell_bb  = 2'd0;
        pair_if.cell_be  = 2'd0;
        pair_if.cell_ei  = 2'd0;
        pair_if.cell_eb  = 2'd0;
        pair_if.cell_ee  = 2'd0;
        pair_if.box_case = BOX_R_IN_S;
        result_if.ready  = 1'b0;

        // reset held low at the start, released on a falling edge away from the sampling edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed script under light sender gaps and heavy receiver stalls;
        // each hex digit holds one cell value in its low two bits
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            for (int i = 0; i < 9; i++)
                txn.cells[i] = script[r].digits[33 - 4 * i -: 2];
            txn.box_case   = script[r].box_case;
            answer.relation = script[r].relation;
            answer.status   = script[r].status;
            send_matrix(txn, script[r].typed, answer);
        end

        // random traffic in three idling regimes; the sender drains the pipe
        // completely before each change of regime
        answer = '0;
        for (int run = 0; run < 3; run++)
        begin
            wait_for_results();
            if (run == 1)
            begin
                send_gap_pct = 56;
                take_gap_pct = 13;
            end
            else if (run == 2)
            begin
                send_gap_pct = 0;
                take_gap_pct = 0;
            end
            for (int n = 0; n < RANDOM_PER_RUN; n++)
                send_matrix(make_random_matrix(), 1'b0, answer);
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_verdicts.size() == 0)
            $display("de9im_topology_classifier: match");
        else
            $display("de9im_topology_classifier: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
design/de9im_pkg.sv
design/de9im_if.sv
design/de9im_decode.sv
design/de9im_match.sv
design/de9im_resolve.sv
design/de9im_topology_classifier.sv
test/tb_de9im_topology_classifier.sv
